// ----- sv/cron_field_mask_parser_assert.svh -----
// Assertion macros for the cron field mask parser checker.
// Expects clk and arst_n to be visible in the scope that expands them.
`ifndef CRON_FIELD_MASK_PARSER_ASSERT_SVH
`define CRON_FIELD_MASK_PARSER_ASSERT_SVH

// antecedent in this cycle, consequent in the next
`define CFMP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cfmp: next-cycle property failed");

// antecedent and consequent in the same cycle
`define CFMP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cfmp: same-cycle property failed");

`endif

// ----- sv/cfmp_pkg.sv -----
// Shared types and constants of the cron field mask parser.
// No dependencies; every other file of the block but the assertion header imports it.
package cfmp_pkg;

	localparam int FIELD_W    = 64;
	localparam int CHAR_W     = 8;
	localparam int VAL_W      = 7;
	localparam int CUR_W      = 8;
	localparam int CNT_W      = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_UNIT_MIN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UNIT_MAX = 1'd1;

	localparam logic [CFG_DATA_W-1:0] UNIT_MIN_RST = 6'd0;
	localparam logic [CFG_DATA_W-1:0] UNIT_MAX_RST = 6'd59;

	localparam logic [VAL_W-1:0] STAR_LAST = 7'd63;

	localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	typedef enum logic [6:0] {
		PH_START = 7'b0000001,
		PH_STAR  = 7'b0000010,
		PH_BEG   = 7'b0000100,
		PH_END   = 7'b0001000,
		PH_STEP  = 7'b0010000,
		PH_XDASH = 7'b0100000,
		PH_XSTEP = 7'b1000000
	} phase_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic load_walk;
		logic walk;
		logic emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;
		logic expand;
		logic fin_ok;
		logic walk_done;
	} sts_t;

endpackage

// ----- sv/cfmp_if.sv -----
// Handshake channels of the cron field mask parser: characters in, masks out.
// Depends on cfmp_pkg for the payload widths.
interface cfmp_char_if
	import cfmp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              last_char;

	modport source (output valid, char_code, last_char, input ready);
	modport sink (input valid, char_code, last_char, output ready);
endinterface

interface cfmp_mask_if
	import cfmp_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] field_mask;
	logic               token_valid;

	modport source (output valid, field_mask, token_valid, input ready);
	modport sink (input valid, field_mask, token_valid, output ready);
endinterface

// ----- sv/cfmp_ctrl.sv -----
// Controller of the cron field mask parser: accepts characters, sequences
// the range walk and loads the output register. Depends on cfmp_pkg.
module cfmp_ctrl
	import cfmp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE     = 4'b0001,
		ST_WALK     = 4'b0010,
		ST_WALK_FIN = 4'b0100,
		ST_EMIT     = 4'b1000
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;

	always_comb begin
		cmd.accept    = accept;
		cmd.load_walk = accept && (sts.last ? sts.fin_ok : sts.expand);
		cmd.walk      = ((state_q == ST_WALK) || (state_q == ST_WALK_FIN)) && !sts.walk_done;
		cmd.emit      = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (sts.last) begin
						state_d = sts.fin_ok ? ST_WALK_FIN : ST_EMIT;
					end else if (sts.expand) begin
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (sts.walk_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_WALK_FIN: begin
				if (sts.walk_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (cmd.emit) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/cfmp_dp.sv -----
// Datapath of the cron field mask parser: token syntax state, unit limits,
// range walker, mask registers and output register. Depends on cfmp_pkg.
module cfmp_dp
	import cfmp_pkg::*;
#(
	parameter int MASK_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CHAR_W-1:0]     char_code,
	input  logic                  last_char,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output logic [FIELD_W-1:0]    field_mask,
	output logic                  token_valid
);

	localparam int IDX_W = $clog2(MASK_BITS);

	function automatic logic [VAL_W-1:0] times_ten_plus(input logic [VAL_W-1:0] x,
		input logic [3:0] d);
		logic [VAL_W+2:0] sum;
		sum = {x, 3'b000} + {2'b00, x, 1'b0} + {(VAL_W-1)'(0), d};
		return sum[VAL_W-1:0];
	endfunction

	// parse state
	phase_t                phase_q, phase_n;
	logic [VAL_W-1:0]      start_q, start_n, end_q, end_n, step_q, step_n;
	logic [CNT_W-1:0]      cnt_q, cnt_n;
	logic                  err_q, err_n, star_q, star_n;
	logic                  fin_ok_q;
	logic [CFG_DATA_W-1:0] unit_min_q, unit_max_q;

	// walker and masks
	logic [CUR_W-1:0]      cur_q;
	logic [VAL_W-1:0]      wend_q, wstep_q;
	logic [MASK_BITS-1:0]  work_q, good_q, out_mask_q;
	logic                  out_tv_q;

	logic                  in_num, n_in_num, is_digit;
	logic [3:0]            digit;
	phase_t                src_phase;
	logic [VAL_W-1:0]      src_start, src_end, src_step;
	logic [CUR_W-1:0]      ld_cur;
	logic [VAL_W-1:0]      ld_end, ld_step;
	logic                  cur_hit;

	assign in_num = (phase_q inside {PH_BEG, PH_END, PH_STEP, PH_XDASH, PH_XSTEP});
	assign n_in_num = (phase_n inside {PH_BEG, PH_END, PH_STEP, PH_XDASH, PH_XSTEP});
	assign is_digit = (char_code inside {[CH_ZERO:CH_NINE]});
	assign digit = char_code[3:0];

	// one character of token syntax
	always_comb begin
		phase_n = phase_q;
		start_n = start_q;
		end_n   = end_q;
		step_n  = step_q;
		cnt_n   = cnt_q;
		err_n   = err_q;
		star_n  = star_q;
		if (!err_q) begin
			if (is_digit) begin
				if (phase_q == PH_START) begin
					phase_n = PH_BEG;
					start_n = {3'b000, digit};
					cnt_n   = 2'd1;
				end else if (in_num && cnt_q < 2'd2) begin
					case (phase_q)
						PH_BEG:  start_n = times_ten_plus(start_q, digit);
						PH_END:  end_n   = times_ten_plus(end_q, digit);
						PH_STEP: step_n  = times_ten_plus(step_q, digit);
						default: ;
					endcase
					cnt_n = cnt_q + 2'd1;
				end else begin
					err_n = 1'b1;
				end
			end else if (char_code == CH_STAR) begin
				if (phase_q == PH_START) begin
					phase_n = PH_STAR;
					star_n  = 1'b1;
				end else begin
					err_n = 1'b1;
				end
			end else if (char_code == CH_COMMA) begin
				if (in_num && cnt_q != 2'd0) begin
					phase_n = PH_BEG;
					start_n = '0;
					end_n   = '0;
					step_n  = '0;
					cnt_n   = 2'd0;
				end else begin
					err_n = 1'b1;
				end
			end else if (char_code == CH_DASH) begin
				if (in_num && cnt_q != 2'd0) begin
					if (phase_q == PH_BEG) begin
						phase_n = PH_END;
						end_n   = '0;
						step_n  = 7'd1;
					end else begin
						phase_n = PH_XDASH;
					end
					cnt_n = 2'd0;
				end else begin
					err_n = 1'b1;
				end
			end else if (char_code == CH_SLASH) begin
				if ((phase_q == PH_END || phase_q == PH_XDASH) && cnt_q != 2'd0) begin
					if (phase_q == PH_END) begin
						phase_n = PH_STEP;
						step_n  = '0;
					end else begin
						phase_n = PH_XSTEP;
					end
					cnt_n = 2'd0;
				end else begin
					err_n = 1'b1;
				end
			end else begin
				err_n = 1'b1;
			end
		end
	end

	// a comma expands the item before it; the last character expands the item it closes
	always_comb begin
		src_phase = last_char ? phase_n : phase_q;
		src_start = last_char ? start_n : start_q;
		src_end   = last_char ? end_n : end_q;
		src_step  = last_char ? step_n : step_q;
		ld_cur    = {1'b0, src_start};
		ld_end    = src_end;
		ld_step   = src_step;
		if (last_char && phase_n == PH_STAR) begin
			ld_cur  = '0;
			ld_end  = STAR_LAST;
			ld_step = 7'd1;
		end else if (src_phase == PH_BEG) begin
			ld_end  = src_start;
			ld_step = 7'd1;
		end else if (src_step == '0) begin
			// zero step: start value alone, nothing when start is past end
			ld_end  = (src_start <= src_end) ? src_start : src_end;
			ld_step = 7'd1;
		end
	end

	always_comb begin
		sts.last      = last_char;
		sts.expand    = !err_q && (char_code == CH_COMMA) && in_num && (cnt_q != 2'd0);
		sts.fin_ok    = !err_n && ((phase_n == PH_STAR && star_n) || (n_in_num && cnt_n != 2'd0));
		sts.walk_done = (cur_q > {1'b0, wend_q});
	end

	assign cur_hit = (cur_q < CUR_W'(MASK_BITS)) && (cur_q >= {2'b00, unit_min_q})
		&& (cur_q <= {2'b00, unit_max_q});

	assign field_mask  = FIELD_W'(out_mask_q);
	assign token_valid = out_tv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			start_q    <= '0;
			end_q      <= '0;
			step_q     <= '0;
			cnt_q      <= '0;
			err_q      <= 1'b0;
			star_q     <= 1'b0;
			fin_ok_q   <= 1'b0;
			unit_min_q <= UNIT_MIN_RST;
			unit_max_q <= UNIT_MAX_RST;
			work_q     <= '0;
			good_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_UNIT_MIN: unit_min_q <= cfg_data;
					REG_UNIT_MAX: unit_max_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				if (last_char) begin
					phase_q  <= PH_START;
					start_q  <= '0;
					end_q    <= '0;
					step_q   <= '0;
					cnt_q    <= '0;
					err_q    <= 1'b0;
					star_q   <= 1'b0;
					fin_ok_q <= sts.fin_ok;
				end else begin
					phase_q <= phase_n;
					start_q <= start_n;
					end_q   <= end_n;
					step_q  <= step_n;
					cnt_q   <= cnt_n;
					err_q   <= err_n;
					star_q  <= star_n;
				end
			end
			if (cmd.emit) begin
				work_q <= '0;
				if (fin_ok_q) begin
					good_q <= work_q;
				end
			end else if (cmd.walk && cur_hit) begin
				work_q[cur_q[IDX_W-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_walk) begin
			cur_q   <= ld_cur;
			wend_q  <= ld_end;
			wstep_q <= ld_step;
		end else if (cmd.walk) begin
			cur_q <= cur_q + {1'b0, wstep_q};
		end
		if (cmd.emit) begin
			out_mask_q <= fin_ok_q ? work_q : good_q;
			out_tv_q   <= fin_ok_q;
		end
	end

endmodule

// ----- sv/cron_field_mask_parser.sv -----
// Cron time-field parser. Takes a token such as "3-15/2,18" or "*" one
// character per transaction, the last one flagged, and returns one mask per
// token with token_valid; an invalid token returns the last good mask with
// token_valid low. A comma that closes an item, and the flagged last character
// of a valid token, start the range walker, which visits one value per cycle
// and holds the input until it sees its end; a star visits 0..63. The flagged
// last character then passes through the emit state, in which the result
// enters the output register. The next character is taken while that result
// waits to be read; a result that is still waiting holds the next one, and the
// input with it.
// Depends on cfmp_pkg, cfmp_if, cfmp_ctrl and cfmp_dp.
module cron_field_mask_parser
	import cfmp_pkg::*;
#(
	parameter int MASK_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cfmp_char_if.sink             char_ch,
	cfmp_mask_if.source           mask_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	cfmp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (char_ch.valid),
		.in_ready  (char_ch.ready),
		.out_valid (mask_ch.valid),
		.out_ready (mask_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cfmp_dp #(
		.MASK_BITS (MASK_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_code   (char_ch.char_code),
		.last_char   (char_ch.last_char),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.sts         (sts),
		.field_mask  (mask_ch.field_mask),
		.token_valid (mask_ch.token_valid)
	);

endmodule

// ----- sv/cfmp_checker.sv -----
// Port-level checker of the cron field mask parser, bound to the top level.
// Depends on cfmp_pkg and cron_field_mask_parser_assert.svh.
`include "cron_field_mask_parser_assert.svh"

module cfmp_checker
	import cfmp_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               char_valid,
	input logic               char_ready,
	input logic               last_char,
	input logic               mask_valid,
	input logic               mask_ready,
	input logic [FIELD_W-1:0] field_mask,
	input logic               token_valid
);

	// a stalled result holds
	`CFMP_ASSERT_NEXT(a_out_hold, mask_valid && !mask_ready, mask_valid && $stable(field_mask) && $stable(token_valid))
	// closing a token always makes the input busy
	`CFMP_ASSERT_NEXT(a_busy_after_last, char_valid && char_ready && last_char, !char_ready)
	// a new result is loaded only from the busy emit cycle
	`CFMP_ASSERT_SAME(a_result_from_busy, $rose(mask_valid), !$past(char_ready))

endmodule

bind cron_field_mask_parser cfmp_checker u_cfmp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.char_valid  (char_ch.valid),
	.char_ready  (char_ch.ready),
	.last_char   (char_ch.last_char),
	.mask_valid  (mask_ch.valid),
	.mask_ready  (mask_ch.ready),
	.field_mask  (mask_ch.field_mask),
	.token_valid (mask_ch.token_valid)
);

// ----- verif/cron_field_mask_parser_check.sv -----
`timescale 1ns / 100ps
// Checker for the cron field mask parser: watches both channels and the register port,
// predicts each token's mask and compares it with the mask transaction that comes back.
// Depends on cfmp_pkg and cfmp_if.
module cron_field_mask_parser_check
	import cfmp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	cfmp_char_if                  char_ch,
	cfmp_mask_if                  mask_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	typedef struct {
		logic [FIELD_W-1:0] mask;
		logic               ok;
	} mask_result_t;

	mask_result_t expected_masks[$];

	// parser state of the token in flight
	logic [FIELD_W-1:0] tok_mask;
	logic [FIELD_W-1:0] last_good_mask;
	int                 item_first;
	int                 item_last;
	int                 item_step;
	int                 ndigits;
	phase_t             phase;
	logic               bad_syntax;
	logic               saw_star;
	logic [CFG_DATA_W-1:0] lim_lo;
	logic [CFG_DATA_W-1:0] lim_hi;

	initial fail_count = 0;
	initial pending = 0;

	task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
			input logic [FIELD_W-1:0] want);
		$display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic void restart_token();
		tok_mask = '0;
		item_first = 0;
		item_last = 0;
		item_step = 0;
		ndigits = 0;
		phase = PH_START;
		bad_syntax = 1'b0;
		saw_star = 1'b0;
	endfunction

	function automatic logic in_number();
		return phase inside {PH_BEG, PH_END, PH_STEP, PH_XDASH, PH_XSTEP};
	endfunction

	function automatic void allow_value(input int v);
		if (v >= lim_lo && v <= lim_hi && v < FIELD_W)
			tok_mask[v] = 1'b1;
	endfunction

	// a single number, or the first range of the comma item with its step
	function automatic void close_item();
		int v;
		if (phase == PH_BEG) begin
			allow_value(item_first);
			return;
		end
		if (item_first > item_last)
			return;
		if (item_step == 0) begin
			allow_value(item_first);
			return;
		end
		for (v = item_first; v <= item_last; v += item_step)
			allow_value(v);
	endfunction

	function automatic void take_char(input logic [CHAR_W-1:0] c);
		logic num;
		int   d;
		num = in_number();
		d = int'(c) - int'(CH_ZERO);
		if (c >= CH_ZERO && c <= CH_NINE) begin
			if (phase == PH_START) begin
				phase = PH_BEG;
				item_first = d;
				ndigits = 1;
			end else if (num && ndigits < 2) begin
				case (phase)
					PH_BEG:  item_first = item_first * 10 + d;
					PH_END:  item_last = item_last * 10 + d;
					PH_STEP: item_step = item_step * 10 + d;
					default: ;
				endcase
				ndigits++;
			end else begin
				bad_syntax = 1'b1;
			end
		end else if (c == CH_STAR) begin
			if (phase == PH_START) begin
				phase = PH_STAR;
				saw_star = 1'b1;
			end else begin
				bad_syntax = 1'b1;
			end
		end else if (c == CH_COMMA) begin
			if (num && ndigits >= 1) begin
				close_item();
				phase = PH_BEG;
				item_first = 0;
				item_last = 0;
				item_step = 0;
				ndigits = 0;
			end else begin
				bad_syntax = 1'b1;
			end
		end else if (c == CH_DASH) begin
			if (num && ndigits >= 1) begin
				if (phase == PH_BEG) begin
					phase = PH_END;
					item_last = 0;
					item_step = 1;
				end else begin
					// later dash parts are only syntax-checked
					phase = PH_XDASH;
				end
				ndigits = 0;
			end else begin
				bad_syntax = 1'b1;
			end
		end else if (c == CH_SLASH) begin
			if ((phase == PH_END || phase == PH_XDASH) && ndigits >= 1) begin
				if (phase == PH_END) begin
					phase = PH_STEP;
					item_step = 0;
				end else begin
					phase = PH_XSTEP;
				end
				ndigits = 0;
			end else begin
				bad_syntax = 1'b1;
			end
		end else begin
			bad_syntax = 1'b1;
		end
	endfunction

	function automatic void finish_token();
		mask_result_t res;
		int           v;
		res.ok = !bad_syntax && ((phase == PH_STAR && saw_star) ||
				(in_number() && ndigits >= 1));
		if (res.ok) begin
			if (phase == PH_STAR) begin
				for (v = 0; v < FIELD_W; v++)
					allow_value(v);
			end else begin
				close_item();
			end
			last_good_mask = tok_mask;
		end
		res.mask = last_good_mask;
		expected_masks.push_back(res);
		restart_token();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mask_result_t want;
		if (!arst_n) begin
			restart_token();
			last_good_mask = '0;
			lim_lo = UNIT_MIN_RST;
			lim_hi = UNIT_MAX_RST;
			expected_masks.delete();
		end else begin
			if (mask_ch.valid && mask_ch.ready) begin
				if (expected_masks.size() == 0) begin
					report_mismatch("unexpected mask transaction", mask_ch.field_mask, '0);
				end else begin
					want = expected_masks.pop_front();
					if (mask_ch.field_mask !== want.mask)
						report_mismatch("field_mask", mask_ch.field_mask, want.mask);
					if (mask_ch.token_valid !== want.ok)
						report_mismatch("token_valid", FIELD_W'(mask_ch.token_valid),
								FIELD_W'(want.ok));
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_UNIT_MIN)
					lim_lo = cfg_data;
				else if (cfg_index == REG_UNIT_MAX)
					lim_hi = cfg_data;
			end
			if (char_ch.valid && char_ch.ready) begin
				if (!bad_syntax)
					take_char(char_ch.char_code);
				if (char_ch.last_char)
					finish_token();
			end
		end
		pending = expected_masks.size();
	end

endmodule

// ----- verif/cron_field_mask_parser_test.sv -----
`timescale 1ns / 100ps
// Top of the cron field mask parser testbench: clock, reset, token stimulus, sink
// stalls, unit range settings and the verdict. Depends on cfmp_pkg, cfmp_if, the
// block and cron_field_mask_parser_check.
module cron_field_mask_parser_test;
	import cfmp_pkg::*;

	localparam int LONG_HOLD      = 400;
	localparam int SETTLE_CYCLES  = 100;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int NUM_PHASES     = 8;
	localparam int PHASE_CHARS    = 128;

	localparam logic [CFG_DATA_W-1:0] LO_SET [NUM_PHASES] = '{0, 63, 40, 1, 0, 0, 17, 0};
	localparam logic [CFG_DATA_W-1:0] HI_SET [NUM_PHASES] = '{63, 63, 10, 31, 0, 59, 45, 59};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    pending;

	logic                  tx_gaps;
	logic                  rx_gaps;
	logic                  rx_hold_req;
	int                    sent_chars;
	int                    idle_cycles;
	logic [CHAR_W-1:0]     tok_chars[$];

	cfmp_char_if char_ch();
	cfmp_mask_if mask_ch();

	cron_field_mask_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_ch   (char_ch),
		.mask_ch   (mask_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cron_field_mask_parser_check i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_ch    (char_ch),
		.mask_ch    (mask_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	// mask sink: random stall bursts, plus one long hold-off on request
	always begin
		@(negedge clk);
		if (rx_hold_req) begin
			mask_ch.ready <= 1'b0;
			repeat (LONG_HOLD) @(negedge clk);
			rx_hold_req = 1'b0;
			mask_ch.ready <= 1'b1;
		end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
			mask_ch.ready <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			mask_ch.ready <= 1'b1;
		end else begin
			mask_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((char_ch.valid && char_ch.ready) || (mask_ch.valid && mask_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// called and returns at a falling edge; valid stays high after the transaction
	task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
		if (tx_gaps && $urandom_range(0, 7) == 0) begin
			char_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		char_ch.valid <= 1'b1;
		char_ch.char_code <= c;
		char_ch.last_char <= last;
		@(posedge clk);
		while (!char_ch.ready)
			@(posedge clk);
		sent_chars++;
		@(negedge clk);
	endtask

	task automatic send_token();
		int i;
		for (i = 0; i < tok_chars.size(); i++)
			send_char(tok_chars[i], i == tok_chars.size() - 1);
	endtask

	task automatic send_text(input string s);
		int i;
		tok_chars.delete();
		for (i = 0; i < s.len(); i++)
			tok_chars.push_back(s[i]);
		send_token();
	endtask

	function automatic logic [CHAR_W-1:0] any_symbol();
		case ($urandom_range(0, 4))
			0: return CH_STAR;
			1: return CH_COMMA;
			2: return CH_DASH;
			3: return CH_SLASH;
			default: return CH_ZERO + CHAR_W'($urandom_range(0, 9));
		endcase
	endfunction

	// one or two digits, mostly landing below 64
	task automatic put_number();
		if ($urandom_range(0, 1)) begin
			if ($urandom_range(0, 3) == 0)
				tok_chars.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
			else
				tok_chars.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 6)));
		end
		tok_chars.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
	endtask

	task automatic make_token();
		int kind;
		tok_chars.delete();
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			tok_chars.push_back(CH_STAR);
		end else if (kind < 88) begin
			put_number();
			repeat ($urandom_range(0, 3)) begin
				case ($urandom_range(0, 2))
					0: begin
						tok_chars.push_back(CH_COMMA);
						put_number();
					end
					1: begin
						tok_chars.push_back(CH_DASH);
						put_number();
					end
					default: begin
						tok_chars.push_back(CH_DASH);
						put_number();
						tok_chars.push_back(CH_SLASH);
						put_number();
					end
				endcase
			end
			// damaged forms of a good token
			if (kind >= 74) begin
				case ($urandom_range(0, 3))
					0: tok_chars[$urandom_range(0, tok_chars.size() - 1)] =
							CHAR_W'($urandom_range(0, 255));
					1: tok_chars.push_back(any_symbol());
					2: begin
						tok_chars.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
						tok_chars.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
					end
					default: tok_chars.push_front(any_symbol());
				endcase
			end
		end else begin
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(0, 1))
					tok_chars.push_back(CHAR_W'($urandom_range(0, 255)));
				else
					tok_chars.push_back(any_symbol());
			end
		end
	endtask

	// drop valid, wait for every mask, then let any walk finish
	task automatic settle();
		char_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_units(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi);
		cfg_we <= 1'b1;
		cfg_index <= REG_UNIT_MIN;
		cfg_data <= lo;
		@(negedge clk);
		cfg_index <= REG_UNIT_MAX;
		cfg_data <= hi;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int p;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_UNIT_MIN;
		cfg_data = '0;
		char_ch.valid = 1'b0;
		char_ch.char_code = '0;
		char_ch.last_char = 1'b0;
		mask_ch.ready = 1'b0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		rx_hold_req = 1'b0;
		sent_chars = 0;
		idle_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed tokens at the reset range 0..59
		send_text("3-15/2,18");
		send_text("*");
		send_text("7-2");
		send_text("4-9/0");
		send_text("1-5-9/2");
		send_text("9,");
		tok_chars.delete();
		tok_chars.push_back(8'hFF);
		tok_chars.push_back(8'h00);
		send_token();
		send_text("99");
		settle();

		for (p = 0; p < NUM_PHASES; p++) begin
			if (p == 6)
				set_units(CFG_DATA_W'($urandom_range(0, 63)), CFG_DATA_W'($urandom_range(0, 63)));
			else
				set_units(LO_SET[p], HI_SET[p]);
			if (p == 2)
				rx_hold_req = 1'b1;
			if (p == NUM_PHASES - 1) begin
				tx_gaps = 1'b0;
				rx_gaps = 1'b0;
			end
			while (sent_chars < 30 + (p + 1) * PHASE_CHARS) begin
				make_token();
				send_token();
			end
			settle();
		end

		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- cron_field_mask_parser.f -----
+incdir+sv
sv/cfmp_pkg.sv
sv/cfmp_if.sv
sv/cfmp_ctrl.sv
sv/cfmp_dp.sv
sv/cron_field_mask_parser.sv
sv/cfmp_checker.sv
verif/cron_field_mask_parser_check.sv
verif/cron_field_mask_parser_test.sv
